[src/nob_pkg.sv]
// Shared types, constants and helpers for the normalise / orthonormal basis unit.
// No dependencies; every other file in src imports this package.
package nob_pkg;

    localparam int IN_W          = 16;
    localparam int V_W           = IN_W + 1;      // raw or negated component
    localparam int OUT_FRAC      = 14;
    localparam int OUT_W         = OUT_FRAC + 2;
    localparam int SQ_W          = 2 * IN_W;      // sum of squares
    localparam int PM_W          = V_W + 32;      // |v| * y
    localparam int RQ_W          = PM_W + 1;
    localparam int NEWTON_STEPS  = 3;
    localparam int NORM_LAT      = 5 + 3 * NEWTON_STEPS + 2;
    localparam int BACK_LAT      = NORM_LAT + 2;
    localparam int R_BASE        = 46 - OUT_FRAC;
    localparam int FIFO_DEPTH    = 2;

    localparam logic [32:0] F_THREE = 33'd3 << 30;
    localparam logic [32:0] Y_LO    = 33'd1 << 30;
    localparam logic [32:0] Y_HI    = 33'd1 << 31;
    localparam logic [RQ_W-1:0] ONE_Q = RQ_W'(1) << OUT_FRAC;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [V_W-1:0] z;
        logic signed [V_W-1:0] y;
        logic signed [V_W-1:0] x;
    } t_vec;

    typedef struct packed {
        logic signed [OUT_W-1:0] z;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] x;
    } t_qvec;

    typedef struct packed {
        t_vec       v;
        t_vec       p;
        logic [1:0] axis;
        logic       deg;
    } t_item;

    typedef struct packed {
        t_qvec      bz;
        t_qvec      by;
        t_qvec      bx;
        logic [1:0] axis;
        logic       deg;
    } t_res;

    typedef struct packed {
        logic [31:0] m;
        logic [3:0]  k;
        t_vec        v;
    } t_nctx;

    // seed approximating 2^46/sqrt(m), indexed by m[31:28]
    function automatic logic [31:0] seed_lookup(input logic [3:0] top);
        logic [31:0] s;
        case (top)
            4'd4:    s = 32'd2024666910;
            4'd5:    s = 32'd1831378350;
            4'd6:    s = 32'd1684623612;
            4'd7:    s = 32'd1568298719;
            4'd8:    s = 32'd1473160898;
            4'd9:    s = 32'd1393472075;
            4'd10:   s = 32'd1325456973;
            4'd11:   s = 32'd1266517136;
            4'd12:   s = 32'd1214801435;
            4'd13:   s = 32'd1168944069;
            4'd14:   s = 32'd1127914247;
            default: s = 32'd1090921693;
        endcase
        return s;
    endfunction

    // clamp a rounded magnitude to 1.0 and restore the sign
    function automatic logic signed [OUT_W-1:0] sat_sign(input logic neg,
                                                         input logic [RQ_W-1:0] q);
        logic [RQ_W-1:0]  c;
        logic [OUT_W-1:0] o;
        c = (q > ONE_Q) ? ONE_Q : q;
        o = c[OUT_W-1:0];
        return neg ? -o : o;
    endfunction

endpackage

[src/nob_front.sv]
// Front end: sign-extends the raw vector, finds the major axis, the
// perpendicular and the zero-vector flag. Depends on nob_pkg.
module nob_front import nob_pkg::*; (
    input  logic [IN_W-1:0] i_vec_x,
    input  logic [IN_W-1:0] i_vec_y,
    input  logic [IN_W-1:0] i_vec_z,
    output t_item           o_item
);
    logic signed [V_W-1:0] w_x, w_y, w_z;
    logic [V_W-1:0]        w_ax, w_ay, w_az;

    assign w_x  = {i_vec_x[IN_W-1], i_vec_x};
    assign w_y  = {i_vec_y[IN_W-1], i_vec_y};
    assign w_z  = {i_vec_z[IN_W-1], i_vec_z};
    assign w_ax = w_x[V_W-1] ? -w_x : w_x;
    assign w_ay = w_y[V_W-1] ? -w_y : w_y;
    assign w_az = w_z[V_W-1] ? -w_z : w_z;

    always_comb begin
        o_item.v.x = w_x;
        o_item.v.y = w_y;
        o_item.v.z = w_z;
        o_item.deg = (w_ax == '0) && (w_ay == '0) && (w_az == '0);
        if (w_ax >= w_ay && w_ax >= w_az) begin
            o_item.axis = AXIS_X;
            o_item.p.x  = -w_y;
            o_item.p.y  = w_x;
            o_item.p.z  = '0;
        end else if (w_ay >= w_az) begin
            o_item.axis = AXIS_Y;
            o_item.p.x  = '0;
            o_item.p.y  = -w_z;
            o_item.p.z  = w_y;
        end else begin
            o_item.axis = AXIS_Z;
            o_item.p.x  = w_z;
            o_item.p.y  = '0;
            o_item.p.z  = -w_x;
        end
    end
endmodule

[src/nob_fifo.sv]
// Short queue of classified items between front and back end.
// Depends on nob_pkg.
module nob_fifo import nob_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);
    localparam int PW = $clog2(FIFO_DEPTH);

    t_item           r_mem [FIFO_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            w_push, w_pop;

    assign o_full  = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end
endmodule

[src/nob_norm.sv]
// Pipelined vector normaliser: sum of squares, even normalising shift,
// seed table and Newton reciprocal square root, scaled rounding. Depends on nob_pkg.
module nob_norm import nob_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_vec  i_v,
    output t_qvec o_n
);
    logic signed [V_W-1:0]   w_vx, w_vy, w_vz;
    logic signed [2*V_W-1:0] w_sqx, w_sqy, w_sqz;
    logic [SQ_W-1:0]         r_sq [3];
    t_vec                    r_v0, r_v1, r_v2, r_v3;
    logic [SQ_W-1:0]         r_sum;
    logic [31:0]             w_m2a, w_m2, r_m2, w_m3a, w_m3, r_m3;
    logic [3:0]              w_k2, r_k2, w_k3, r_k3;

    logic [31:0] r_y   [NEWTON_STEPS+1];
    t_nctx       r_cy  [NEWTON_STEPS+1];
    logic [31:0] r_t   [NEWTON_STEPS];
    logic [31:0] r_yt  [NEWTON_STEPS];
    t_nctx       r_ct  [NEWTON_STEPS];
    logic [31:0] r_f   [NEWTON_STEPS];
    logic [31:0] r_yu  [NEWTON_STEPS];
    t_nctx       r_cu  [NEWTON_STEPS];

    assign w_vx  = i_v.x;
    assign w_vy  = i_v.y;
    assign w_vz  = i_v.z;
    assign w_sqx = w_vx * w_vx;
    assign w_sqy = w_vy * w_vy;
    assign w_sqz = w_vz * w_vz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq[0] <= w_sqx[SQ_W-1:0];
            r_sq[1] <= w_sqy[SQ_W-1:0];
            r_sq[2] <= w_sqz[SQ_W-1:0];
            r_v0    <= i_v;
            r_sum   <= r_sq[0] + r_sq[1] + r_sq[2];
            r_v1    <= r_v0;
        end
    end

    // shift by whole bit pairs until the top pair is non-zero
    always_comb begin
        w_k2  = '0;
        w_m2a = r_sum;
        if (r_sum[31:16] == '0) begin
            w_m2a = r_sum << 16;
            w_k2  = 4'd8;
        end
        w_m2 = w_m2a;
        if (w_m2a[31:24] == '0) begin
            w_m2 = w_m2a << 8;
            w_k2 = w_k2 + 4'd4;
        end
        w_k3  = r_k2;
        w_m3a = r_m2;
        if (r_m2[31:28] == '0) begin
            w_m3a = r_m2 << 4;
            w_k3  = w_k3 + 4'd2;
        end
        w_m3 = w_m3a;
        if (w_m3a[31:30] == '0) begin
            w_m3 = w_m3a << 2;
            w_k3 = w_k3 + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m2    <= w_m2;
            r_k2    <= w_k2;
            r_v2    <= r_v1;
            r_m3    <= w_m3;
            r_k3    <= w_k3;
            r_v3    <= r_v2;
            r_y[0]  <= seed_lookup(r_m3[31:28] - 4'd4 > 4'd11 ? 4'd15 : r_m3[31:28]);
            r_cy[0] <= '{m: r_m3, k: r_k3, v: r_v3};
        end
    end

    for (genvar j = 0; j < NEWTON_STEPS; j++) begin : g_nr
        logic [63:0] w_tt, w_uu, w_yy;
        logic [32:0] w_u, w_yn, w_yc;

        assign w_tt = 64'(r_y[j]) * 64'(r_y[j]);
        assign w_uu = 64'(r_ct[j].m) * 64'(r_t[j]);
        assign w_u  = w_uu[63:31];
        assign w_yy = 64'(r_yu[j]) * 64'(r_f[j]);
        assign w_yn = w_yy[63:31];
        assign w_yc = (w_yn < Y_LO) ? Y_LO : ((w_yn > Y_HI) ? Y_HI : w_yn);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[j]    <= w_tt[62:31];
                r_yt[j]   <= r_y[j];
                r_ct[j]   <= r_cy[j];
                r_f[j]    <= (w_u >= F_THREE) ? '0 : 32'(F_THREE - w_u);
                r_yu[j]   <= r_yt[j];
                r_cu[j]   <= r_ct[j];
                r_y[j+1]  <= w_yc[31:0];
                r_cy[j+1] <= r_cu[j];
            end
        end
    end

    // output scaling
    t_nctx                 w_cf;
    logic signed [V_W-1:0] w_c [3];
    logic [V_W-1:0]        w_mag [3];
    logic [PM_W-1:0]       r_pm [3];
    logic                  r_neg [3];
    logic [3:0]            r_kf;
    logic [5:0]            w_sh;
    logic [RQ_W-1:0]       w_rq [3];

    assign w_cf   = r_cy[NEWTON_STEPS];
    assign w_c[0] = w_cf.v.x;
    assign w_c[1] = w_cf.v.y;
    assign w_c[2] = w_cf.v.z;
    assign w_sh   = 6'(R_BASE) - {2'b00, r_kf};

    for (genvar i = 0; i < 3; i++) begin : g_out
        assign w_mag[i] = w_c[i][V_W-1] ? -w_c[i] : w_c[i];
        assign w_rq[i]  = ({1'b0, r_pm[i]} + (RQ_W'(1) << (w_sh - 6'd1))) >> w_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pm[i]  <= PM_W'(w_mag[i]) * PM_W'(r_y[NEWTON_STEPS]);
                r_neg[i] <= w_c[i][V_W-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kf  <= w_cf.k;
            o_n.x <= sat_sign(r_neg[0], w_rq[0]);
            o_n.y <= sat_sign(r_neg[1], w_rq[1]);
            o_n.z <= sat_sign(r_neg[2], w_rq[2]);
        end
    end
endmodule

[src/nob_back.sv]
// Back end: two normalisers in lockstep, cross product, axis placement and
// the output register. Depends on nob_pkg and nob_norm.
module nob_back import nob_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_item_valid,
    input  t_item i_item,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_res  o_res
);
    logic       w_en;
    logic       r_vld [BACK_LAT];
    logic [1:0] r_ax  [BACK_LAT-1];
    logic       r_dg  [BACK_LAT-1];
    t_qvec      w_n, w_p, r_n, r_p;
    logic signed [2*OUT_W-1:0] r_pr [6];
    logic signed [OUT_W-1:0]   w_a [3], w_b [3];
    t_qvec      w_c;

    assign w_en    = !r_vld[BACK_LAT-1] || i_ready;
    assign o_pop   = w_en && i_item_valid;
    assign o_valid = r_vld[BACK_LAT-1];

    nob_norm u_norm_major (.i_clk(i_clk), .i_en(w_en), .i_v(i_item.v), .o_n(w_n));
    nob_norm u_norm_perp  (.i_clk(i_clk), .i_en(w_en), .i_v(i_item.p), .o_n(w_p));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BACK_LAT; i++) r_vld[i] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_item_valid;
            for (int i = 1; i < BACK_LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax[0] <= i_item.axis;
            r_dg[0] <= i_item.deg;
            for (int i = 1; i < BACK_LAT - 1; i++) begin
                r_ax[i] <= r_ax[i-1];
                r_dg[i] <= r_dg[i-1];
            end
        end
    end

    assign w_a[0] = w_n.x;
    assign w_a[1] = w_n.y;
    assign w_a[2] = w_n.z;
    assign w_b[0] = w_p.x;
    assign w_b[1] = w_p.y;
    assign w_b[2] = w_p.z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n     <= w_n;
            r_p     <= w_p;
            r_pr[0] <= w_a[1] * w_b[2];
            r_pr[1] <= w_a[2] * w_b[1];
            r_pr[2] <= w_a[2] * w_b[0];
            r_pr[3] <= w_a[0] * w_b[2];
            r_pr[4] <= w_a[0] * w_b[1];
            r_pr[5] <= w_a[1] * w_b[0];
        end
    end

    function automatic logic signed [OUT_W-1:0] cross_term(
        input logic signed [2*OUT_W-1:0] p1,
        input logic signed [2*OUT_W-1:0] p2
    );
        logic signed [2*OUT_W:0] d;
        logic [2*OUT_W:0]        mg;
        logic [2*OUT_W:0]        q;
        d  = {p1[2*OUT_W-1], p1} - {p2[2*OUT_W-1], p2};
        mg = d[2*OUT_W] ? -d : d;
        q  = (mg + ((2*OUT_W+1)'(1) << (OUT_FRAC - 1))) >> OUT_FRAC;
        return sat_sign(d[2*OUT_W], RQ_W'(q));
    endfunction

    assign w_c.x = cross_term(r_pr[0], r_pr[1]);
    assign w_c.y = cross_term(r_pr[2], r_pr[3]);
    assign w_c.z = cross_term(r_pr[4], r_pr[5]);

    // cyclic placement: major, then perpendicular, then their cross product
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_res.axis <= r_ax[BACK_LAT-2];
            o_res.deg  <= r_dg[BACK_LAT-2];
            if (r_dg[BACK_LAT-2]) begin
                o_res.bx <= '0;
                o_res.by <= '0;
                o_res.bz <= '0;
            end else begin
                unique case (r_ax[BACK_LAT-2])
                    AXIS_Y: begin
                        o_res.by <= r_n;
                        o_res.bz <= r_p;
                        o_res.bx <= w_c;
                    end
                    AXIS_Z: begin
                        o_res.bz <= r_n;
                        o_res.bx <= r_p;
                        o_res.by <= w_c;
                    end
                    default: begin
                        o_res.bx <= r_n;
                        o_res.by <= r_p;
                        o_res.bz <= w_c;
                    end
                endcase
            end
        end
    end
endmodule

[src/normalize_and_orthonormal_basis_unit.sv]
// Top level of the normalise / orthonormal basis unit.
// Depends on nob_pkg, nob_front, nob_fifo, nob_back.
//
// Input stream: one raw signed vector per transfer on the s channel.
// Output stream: one right-handed orthonormal basis per input on the m channel,
// Q1.14 components, with the major axis and a zero-vector flag in tuser.
// Throughput: one vector per cycle while the receiver keeps tready high.
// Pipeline: queue write on the transfer edge, then two normalisers of 16 stages
// each running in lockstep and two cross-product stages.
// The rate is set by the pipelined Newton iterations, one multiply per stage.
// When the receiver stalls, the whole back pipeline holds; the front keeps
// taking items until the two-entry queue is full, then drops s_tready.
// A zero input gives all-zero basis vectors, major axis X and the flag set.
// Reset (synchronous, active low) empties the queue and the pipeline valids;
// no clearing pass is needed.
module normalize_and_orthonormal_basis_unit import nob_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [47:0]  i_s_tdata,   // vec_x, vec_y, vec_z
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [143:0] o_m_tdata,   // basis_x_x..z, basis_y_x..z, basis_z_x..z
    output logic [2:0]   o_m_tuser    // major_axis, degenerate
);
    t_item w_item, w_head;
    logic  w_full, w_head_valid, w_pop;
    t_res  w_res;

    nob_front u_front (
        .i_vec_x (i_s_tdata[15:0]),
        .i_vec_y (i_s_tdata[31:16]),
        .i_vec_z (i_s_tdata[47:32]),
        .o_item  (w_item)
    );

    nob_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_item  (w_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_item  (w_head)
    );

    nob_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_head_valid),
        .i_item       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_res        (w_res)
    );

    assign o_s_tready = !w_full;
    assign o_m_tdata  = {w_res.bz.z, w_res.bz.y, w_res.bz.x,
                         w_res.by.z, w_res.by.y, w_res.by.x,
                         w_res.bx.z, w_res.bx.y, w_res.bx.x};
    assign o_m_tuser  = {w_res.deg, w_res.axis};
endmodule
